>>> src/ogg_page_deframer_top_defines.svh
// Assertion helpers shared by the deframer; clocked on clk_i, off during reset.
`ifndef OGG_PAGE_DEFRAMER_TOP_DEFINES_SVH
`define OGG_PAGE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define OPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication.
`define OPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> src/opd_pkg.sv
package opd_pkg;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_SEGS    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  localparam logic [7:0] CAP_O = 8'h4F;
  localparam logic [7:0] CAP_G = 8'h67;
  localparam logic [7:0] CAP_S = 8'h53;

  localparam logic [4:0] HDR_FIRST_POS = 5'd4;
  localparam logic [4:0] TYPE_POS      = 5'd5;
  localparam logic [4:0] SERIAL_POS    = 5'd14;
  localparam logic [4:0] SEG_COUNT_POS = 5'd26;
  localparam logic [7:0] FLAG_BOS      = 8'h02;
  localparam logic [7:0] FLAG_EOS      = 8'h04;

  // Work item handed from the parser to the output side.
  typedef struct packed {
    logic        is_pattern;
    logic [7:0]  data;
    logic        page_end;
    logic [31:0] serial;
    logic        bos;
    logic        eos;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = CAP_O;
      2'd1:    r = CAP_G;
      2'd2:    r = CAP_G;
      default: r = CAP_S;
    endcase
    return r;
  endfunction

endpackage

>>> src/opd_front.sv
module opd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  output logic            push_o,
  output opd_pkg::entry_t entry_o
);

  opd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  pm_q, pm_d;
  logic [4:0]  hpos_q, hpos_d;
  logic [7:0]  segleft_q, segleft_d;
  logic [15:0] payload_q, payload_d;
  logic [31:0] serial_q, serial_d;
  logic [1:0]  flags_q, flags_d;

  logic [15:0] pay_sum;
  logic [15:0] pay_dec;
  logic [7:0]  seg_dec;
  logic [4:0]  lane_off;
  logic        page_end;

  assign pay_sum  = payload_q + {8'd0, data_byte_i};
  assign pay_dec  = (payload_q != 16'd0) ? payload_q - 16'd1 : payload_q;
  assign seg_dec  = (segleft_q != 8'd0) ? segleft_q - 8'd1 : segleft_q;
  assign lane_off = hpos_q - opd_pkg::SERIAL_POS;

  always_comb begin
    phase_d   = phase_q;
    pm_d      = pm_q;
    hpos_d    = hpos_q;
    segleft_d = segleft_q;
    payload_d = payload_q;
    serial_d  = serial_q;
    flags_d   = flags_q;
    push_o    = 1'b0;
    page_end  = 1'b0;
    entry_o   = '0;
    if (accept_i) begin
      case (phase_q)
        opd_pkg::PH_HUNT: begin
          if (data_byte_i == opd_pkg::capture_byte(pm_q[1:0])) begin
            if (pm_q == 3'd3) begin
              pm_d     = 3'd0;
              serial_d = 32'd0;
              flags_d  = 2'd0;
              hpos_d   = opd_pkg::HDR_FIRST_POS;
              phase_d  = opd_pkg::PH_HEADER;
              push_o   = 1'b1;
            end else begin
              pm_d = pm_q + 3'd1;
            end
          end else begin
            pm_d = (data_byte_i == opd_pkg::CAP_O) ? 3'd1 : 3'd0;
          end
        end
        opd_pkg::PH_HEADER: begin
          push_o = 1'b1;
          if (hpos_q == opd_pkg::TYPE_POS) begin
            flags_d = {|(data_byte_i & opd_pkg::FLAG_EOS), |(data_byte_i & opd_pkg::FLAG_BOS)};
          end
          if (hpos_q inside {[opd_pkg::SERIAL_POS:opd_pkg::SERIAL_POS + 5'd3]}) begin
            serial_d[{lane_off[1:0], 3'b000} +: 8] =
              serial_q[{lane_off[1:0], 3'b000} +: 8] | data_byte_i;
          end
          if (hpos_q >= opd_pkg::SEG_COUNT_POS) begin
            segleft_d = data_byte_i;
            payload_d = 16'd0;
            hpos_d    = 5'd0;
            if (data_byte_i == 8'd0) begin
              page_end = 1'b1;
              phase_d  = opd_pkg::PH_HUNT;
            end else begin
              phase_d = opd_pkg::PH_SEGS;
            end
          end else begin
            hpos_d = hpos_q + 5'd1;
          end
        end
        opd_pkg::PH_SEGS: begin
          push_o    = 1'b1;
          payload_d = pay_sum;
          segleft_d = seg_dec;
          if (seg_dec == 8'd0) begin
            if (pay_sum == 16'd0) begin
              page_end = 1'b1;
              phase_d  = opd_pkg::PH_HUNT;
            end else begin
              phase_d = opd_pkg::PH_PAYLOAD;
            end
          end
        end
        opd_pkg::PH_PAYLOAD: begin
          push_o    = 1'b1;
          payload_d = pay_dec;
          if (pay_dec == 16'd0) begin
            page_end = 1'b1;
            phase_d  = opd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_d = opd_pkg::PH_HUNT;
        end
      endcase
    end
    entry_o.is_pattern = (phase_q == opd_pkg::PH_HUNT);
    entry_o.data       = data_byte_i;
    entry_o.page_end   = page_end;
    entry_o.serial     = page_end ? serial_d : 32'd0;
    entry_o.bos        = page_end & flags_d[0];
    entry_o.eos        = page_end & flags_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= opd_pkg::PH_HUNT;
      pm_q      <= 3'd0;
      hpos_q    <= 5'd0;
      segleft_q <= 8'd0;
      payload_q <= 16'd0;
      serial_q  <= 32'd0;
      flags_q   <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      pm_q      <= pm_d;
      hpos_q    <= hpos_d;
      segleft_q <= segleft_d;
      payload_q <= payload_d;
      serial_q  <= serial_d;
      flags_q   <= flags_d;
    end
  end

endmodule

>>> src/opd_queue.sv
module opd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  opd_pkg::entry_t entry_i,
  input  logic            pop_i,
  output opd_pkg::entry_t head_o,
  output opd_pkg::qstat_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  opd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
    end
  end

endmodule

>>> src/opd_back.sv
module opd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  opd_pkg::entry_t head_i,
  input  opd_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            page_start_o,
  output logic            page_end_o,
  output logic [31:0]     stream_serial_o,
  output logic            begins_stream_o,
  output logic            ends_stream_o,
  output logic            run_last_o
);

  logic [1:0]  beat_q, beat_d;
  logic        valid_q;
  logic        load;
  logic        last_beat;
  logic [7:0]  byte_q;
  logic        start_q, end_q, bos_q, eos_q, last_q;
  logic [31:0] serial_q;

  // Refill the output register when it is empty or being taken.
  assign load      = !qstat_i.empty && (!valid_q || !out_stall_i);
  assign last_beat = !head_i.is_pattern || (beat_q == 2'd3);
  assign pop_o     = load && last_beat;

  always_comb begin
    beat_d = beat_q;
    if (load) begin
      beat_d = last_beat ? 2'd0 : beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 2'd0;
    end else begin
      beat_q <= beat_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.is_pattern) begin
        byte_q   <= opd_pkg::capture_byte(beat_q);
        start_q  <= (beat_q == 2'd0);
        end_q    <= 1'b0;
        serial_q <= 32'd0;
        bos_q    <= 1'b0;
        eos_q    <= 1'b0;
      end else begin
        byte_q   <= head_i.data;
        start_q  <= 1'b0;
        end_q    <= head_i.page_end;
        serial_q <= head_i.serial;
        bos_q    <= head_i.bos;
        eos_q    <= head_i.eos;
      end
      last_q <= last_beat;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign page_start_o    = start_q;
  assign page_end_o      = end_q;
  assign stream_serial_o = serial_q;
  assign begins_stream_o = bos_q;
  assign ends_stream_o   = eos_q;
  assign run_last_o      = last_q;

endmodule

>>> src/ogg_page_deframer_top.sv
// Ogg page deframer. Takes one stream byte per beat, drops bytes until the
// capture pattern "OggS" is seen, then emits the page: the four pattern bytes
// (page_start on the O), the rest of the header, the segment table and the
// payload. The beat carrying a page's last byte has page_end set along with the
// serial number and the begin/end of stream flags. Throughput is one input byte
// per cycle while in_stall_o is low; the byte that completes the pattern yields
// four output beats, which the output side drains while the parser keeps taking
// bytes into a QDepth-entry queue. in_stall_o rises only while that queue is
// full. An accepted byte passes through the queue and then the output register.
// No CRC or version check is made.
`include "ogg_page_deframer_top_defines.svh"

module ogg_page_deframer_top #(
  parameter int unsigned QDepth = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        page_start_o,
  output logic        page_end_o,
  output logic [31:0] stream_serial_o,
  output logic        begins_stream_o,
  output logic        ends_stream_o,
  output logic        run_last_o
);

  opd_pkg::entry_t push_entry;
  opd_pkg::entry_t head;
  opd_pkg::qstat_t qstat;
  logic            accept;
  logic            push;
  logic            pop;

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  opd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  opd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (qstat)
  );

  opd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .page_start_o    (page_start_o),
    .page_end_o      (page_end_o),
    .stream_serial_o (stream_serial_o),
    .begins_stream_o (begins_stream_o),
    .ends_stream_o   (ends_stream_o),
    .run_last_o      (run_last_o)
  );

  `OPD_ASSERT_NOW(a_start_is_o, out_valid_o && page_start_o, out_byte_o == opd_pkg::CAP_O)
  `OPD_ASSERT_NOW(a_start_not_last, out_valid_o && page_start_o, !run_last_o && !page_end_o)
  `OPD_ASSERT_NOW(a_end_is_last, out_valid_o && page_end_o, run_last_o)
  `OPD_ASSERT_NOW(a_no_push_full, push, !qstat.full)
  `OPD_ASSERT_NEXT(a_pop_fills_out, pop, out_valid_o)

endmodule

>>> dv/ogg_page_deframer_top_tb.sv
module ogg_page_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;
  // Capture pattern, first byte in the low lane.
  localparam logic [31:0] OggsWord = {CAP_S, CAP_G, CAP_G, CAP_O};

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic        stop;
    logic [31:0] serial;
    logic        bos;
    logic        eos;
    logic        run_last;
  } page_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        page_start_o;
  logic        page_end_o;
  logic [31:0] stream_serial_o;
  logic        begins_stream_o;
  logic        ends_stream_o;
  logic        run_last_o;

  page_beat_t  page_beats_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_on = 1'b0;

  // Deframer state as predicted
  phase_e      cur_phase;
  logic [2:0]  matched;
  logic [4:0]  hdr_pos;
  logic [7:0]  segs_left;
  logic [15:0] lace_sum;
  logic [31:0] serial_acc;
  logic [1:0]  flags;

  ogg_page_deframer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .page_start_o    (page_start_o),
    .page_end_o      (page_end_o),
    .stream_serial_o (stream_serial_o),
    .begins_stream_o (begins_stream_o),
    .ends_stream_o   (ends_stream_o),
    .run_last_o      (run_last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $realtime, page_beats_q.size());
      $display("ogg_page_deframer_top test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  function automatic void push_beat(input logic [7:0] b, input logic first,
                                    input logic last_of_page, input logic run_end);
    page_beat_t e;
    e.data     = b;
    e.start    = first;
    e.stop     = last_of_page;
    e.serial   = last_of_page ? serial_acc : 32'h0;
    e.bos      = last_of_page & flags[0];
    e.eos      = last_of_page & flags[1];
    e.run_last = run_end;
    page_beats_q.push_back(e);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic last_of_page;
    last_of_page = 1'b0;
    case (cur_phase)
      PH_HEADER: begin
        if (hdr_pos == TYPE_POS) begin
          flags = {(b & FLAG_EOS) != 8'h00, (b & FLAG_BOS) != 8'h00};
        end
        if (hdr_pos >= SERIAL_POS && hdr_pos < SERIAL_POS + 5'd4) begin
          serial_acc |= 32'(b) << (8 * (hdr_pos - SERIAL_POS));
        end
        if (hdr_pos >= SEG_COUNT_POS) begin
          segs_left = b;
          lace_sum  = 16'h0;
          hdr_pos   = 5'd0;
          if (b == 8'h00) begin
            last_of_page = 1'b1;
            cur_phase    = PH_HUNT;
          end else begin
            cur_phase = PH_SEGS;
          end
        end else begin
          hdr_pos++;
        end
      end
      PH_SEGS: begin
        lace_sum += 16'(b);
        if (segs_left != 8'h00) segs_left--;
        if (segs_left == 8'h00) begin
          if (lace_sum == 16'h0) begin
            last_of_page = 1'b1;
            cur_phase    = PH_HUNT;
          end else begin
            cur_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (lace_sum != 16'h0) lace_sum--;
        if (lace_sum == 16'h0) begin
          last_of_page = 1'b1;
          cur_phase    = PH_HUNT;
        end
      end
      default: begin
        // Hunt: drop the byte; restart on a mismatch, counting a fresh O.
        if (b == OggsWord[8*matched[1:0] +: 8]) begin
          matched++;
          if (matched == 3'd4) begin
            matched    = 3'd0;
            serial_acc = 32'h0;
            flags      = 2'b00;
            hdr_pos    = HDR_FIRST_POS;
            cur_phase  = PH_HEADER;
            for (int i = 0; i < 4; i++) begin
              push_beat(OggsWord[8*i +: 8], i == 0, 1'b0, i == 3);
            end
          end
        end else begin
          matched = (b == CAP_O) ? 3'd1 : 3'd0;
        end
        return;
      end
    endcase
    push_beat(b, 1'b0, last_of_page, 1'b1);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    page_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (page_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual byte %h",
                 $realtime, out_byte_o);
        mismatch_cnt++;
      end else begin
        want = page_beats_q.pop_front();
        check_field("out_byte", 32'(want.data), 32'(out_byte_o));
        check_field("page_start", 32'(want.start), 32'(page_start_o));
        check_field("page_end", 32'(want.stop), 32'(page_end_o));
        check_field("stream_serial", want.serial, stream_serial_o);
        check_field("begins_stream", 32'(want.bos), 32'(begins_stream_o));
        check_field("ends_stream", 32'(want.eos), 32'(ends_stream_o));
        check_field("run_last", 32'(want.run_last), 32'(run_last_o));
      end
    end
  end

  // Offer one byte, hold it until taken; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_page(input logic [7:0] htype, input logic [31:0] serial,
                           input int nseg, input int lace_lo, input int lace_hi);
    logic [7:0] pg[$];
    int         payload_len;
    int         lace;
    payload_len = 0;
    pg = {CAP_O, CAP_G, CAP_G, CAP_S, 8'($urandom), htype};
    repeat (8) pg.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) pg.push_back(serial[8*i +: 8]);
    repeat (8) pg.push_back(8'($urandom));
    pg.push_back(8'(nseg));
    repeat (nseg) begin
      lace = $urandom_range(lace_hi, lace_lo);
      payload_len += lace;
      pg.push_back(8'(lace));
    end
    repeat (payload_len) pg.push_back(8'($urandom));
    foreach (pg[i]) send_byte(pg[i]);
  endtask

  task automatic test_hunt_restart();
    logic [7:0] junk[$];
    junk = {8'h00, 8'hFF, CAP_O, CAP_O, CAP_G, CAP_G, 8'h00, CAP_O, CAP_G, CAP_O,
            CAP_G, CAP_G, CAP_O, CAP_G, CAP_G, 8'hFF, CAP_S, CAP_G, CAP_S};
    foreach (junk[i]) send_byte(junk[i]);
  endtask

  task automatic test_empty_pages();
    send_page(FLAG_BOS | FLAG_EOS, 32'hFFFF_FFFF, 0, 0, 0);
  endtask

  task automatic test_zero_lacing();
    send_page(FLAG_EOS, $urandom, 2, 0, 0);
  endtask

  task automatic test_full_lacing();
    send_page(8'($urandom), $urandom, 1, 0, 20);
  endtask

  // Mostly whole pages, with noise and partial capture patterns mixed in.
  task automatic test_random_pages(input int unsigned n_bytes, input int unsigned idle,
                                   input int unsigned stall);
    int unsigned stop_at;
    int unsigned pick;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_page(8'($urandom), $urandom, $urandom_range(2, 1), 0, 6);
      end else if (pick < 8) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end else begin
        for (int i = 0; i < int'($urandom_range(3, 1)); i++) begin
          send_byte(OggsWord[8*i +: 8]);
        end
        send_byte(8'($urandom));
      end
    end
  endtask

  // Hold the output off for a long stretch while a page keeps coming in.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_on = 1'b1;
        repeat (80) @(negedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    send_page(8'($urandom), $urandom, 1, 4, 8);
  endtask

  initial begin
    cur_phase  = PH_HUNT;
    matched    = 3'd0;
    hdr_pos    = 5'd0;
    segs_left  = 8'h00;
    lace_sum   = 16'h0;
    serial_acc = 32'h0;
    flags      = 2'b00;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_hunt_restart();
    test_empty_pages();
    test_zero_lacing();
    test_full_lacing();
    test_random_pages(8, 0, 0);
    test_backpressure();
    test_random_pages(8, 56, 0);
    test_random_pages(8, 0, 56);
    test_random_pages(8, 6, 6);

    in_valid_i <= 1'b0;
    while (page_beats_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ogg_page_deframer_top test passed");
    end else begin
      $display("ogg_page_deframer_top test failed");
    end
    $finish;
  end

endmodule
